@@ design/mtrt_pkg.sv @@
// shared types, codes and constants for the memory type range table
package mtrt_pkg;

	localparam int unsigned MAX_RANGES_DEF = 8;
	localparam int unsigned PAGE_BYTES     = 4096;
	localparam int unsigned PAGE_SHIFT     = 12;
	localparam int unsigned PAGE_W         = 32 - PAGE_SHIFT;
	localparam int unsigned ENTRY_W        = 2 * PAGE_W;
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CFG_DATA_W     = 8;

	localparam logic [7:0] TYPE_WC = 8'd1;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_CHECK  = 2'd1;
	localparam logic [1:0] KIND_ADD    = 2'd2;

	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_ALREADY     = 3'd1;
	localparam logic [2:0] STAT_UNALIGNED   = 3'd2;
	localparam logic [2:0] STAT_UNSUPPORTED = 3'd3;
	localparam logic [2:0] STAT_NO_FREE     = 3'd4;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_CHECK  = 3'd2;
	localparam logic [2:0] OP_ADD    = 3'd3;
	localparam logic [2:0] OP_REJECT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WC_SUPPORTED = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [30:0] length;
	} req_t;

	typedef struct packed {
		logic [7:0] mem_type;
		logic       range_is_wc;
		logic [2:0] status;
		logic [2:0] slot;
	} res_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        status;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] pages;
		logic [PAGE_W-1:0] mask;
	} cmd_t;

endpackage

@@ design/mtrt_front.sv @@
// request intake: acceptance, classification, add checks and mask build
module mtrt_front (
	input  logic          start,
	input  mtrt_pkg::req_t request,
	input  logic          wc_supported,
	input  logic          full,
	output logic          push,
	output logic          busy,
	output mtrt_pkg::cmd_t cmd
);
	import mtrt_pkg::*;

	logic [31:0] len_ext;
	logic [31:0] len_m1;
	logic [31:0] sm;
	logic [31:0] rnd;
	logic        unaligned;

	assign busy = full;
	assign push = start && !full;

	always_comb begin
		len_ext = {1'b0, request.length};
		len_m1  = len_ext - 32'd1;
		sm      = len_m1 | (len_m1 >> 1);
		sm      = sm | (sm >> 2);
		sm      = sm | (sm >> 4);
		sm      = sm | (sm >> 8);
		sm      = sm | (sm >> 16);
		rnd     = len_ext + 32'(PAGE_BYTES - 1);
		unaligned = (request.length == 31'd0) ||
			((request.address[PAGE_SHIFT-1:0] | request.length[PAGE_SHIFT-1:0]) != '0);

		cmd.op     = OP_NONE;
		cmd.status = STAT_OK;
		cmd.page   = request.address[31:PAGE_SHIFT];
		cmd.pages  = rnd[31:PAGE_SHIFT];
		cmd.mask   = ~sm[31:PAGE_SHIFT];

		unique case (request.kind)
			KIND_LOOKUP: cmd.op = OP_LOOKUP;
			KIND_CHECK:  cmd.op = OP_CHECK;
			KIND_ADD: begin
				priority if (unaligned) begin
					cmd.op     = OP_REJECT;
					cmd.status = STAT_UNALIGNED;
				end else if (!wc_supported) begin
					cmd.op     = OP_REJECT;
					cmd.status = STAT_UNSUPPORTED;
				end else begin
					cmd.op = OP_ADD;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ design/mtrt_queue.sv @@
// short command queue between intake and execution
module mtrt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mtrt_pkg::cmd_t wdata,
	input  logic          pop,
	output mtrt_pkg::cmd_t rdata,
	output logic          empty,
	output logic          full
);
	import mtrt_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign rdata = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/mtrt_back.sv @@
// execution: range table memory, entry scan, page walk and free slot search
module mtrt_back #(
	parameter int unsigned MAX_RANGES = mtrt_pkg::MAX_RANGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mtrt_pkg::cmd_t q_data,
	input  logic          q_empty,
	output logic          pop,
	input  logic [7:0]    default_type,
	input  logic [3:0]    range_count,
	output logic          done,
	output mtrt_pkg::res_t result
);
	import mtrt_pkg::*;

	localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned NUM_W = $clog2(MAX_RANGES + 1);
	localparam int unsigned CW    = (NUM_W > 4) ? NUM_W : 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;

	logic [ENTRY_W-1:0]    mem_q [MAX_RANGES];
	logic [ENTRY_W-1:0]    rdata_q;
	logic [MAX_RANGES-1:0] valid_q;

	logic [1:0]        state_q;
	logic [2:0]        op_q;
	logic [PAGE_W-1:0] base_q;
	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] pages_q;
	logic [PAGE_W-1:0] mask_q;
	logic [CW-1:0]     ridx_q;
	logic [IDX_W-1:0]  cidx_q;
	logic              cmpv_q;
	logic [CW-1:0]     fidx_q;
	logic              done_q;
	res_t              res_q;

	logic [CW-1:0]     rc_ext;
	logic [CW-1:0]     n_act;
	logic [PAGE_W-1:0] rbase;
	logic [PAGE_W-1:0] rmask;
	logic              issue;
	logic              hit;
	logic              page_done;
	logic [7:0]        page_type;
	logic              rd_en;
	logic              wr_en;
	logic              free_end;

	assign rc_ext    = CW'(range_count);
	assign n_act     = (rc_ext > CW'(MAX_RANGES)) ? CW'(MAX_RANGES) : rc_ext;
	assign rbase     = rdata_q[ENTRY_W-1:PAGE_W];
	assign rmask     = rdata_q[PAGE_W-1:0];
	assign issue     = ridx_q < n_act;
	assign hit       = cmpv_q && valid_q[cidx_q] && (((page_q ^ rbase) & rmask) == '0);
	assign page_done = hit || !issue;
	assign page_type = hit ? TYPE_WC : default_type;
	assign rd_en     = (state_q == ST_SCAN) && !page_done;
	assign free_end  = fidx_q >= n_act;
	assign wr_en     = (state_q == ST_FREE) && !free_end && !valid_q[fidx_q[IDX_W-1:0]];
	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign done      = done_q;
	assign result    = res_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[fidx_q[IDX_W-1:0]] <= {base_q, mask_q};
		end
		if (rd_en) begin
			rdata_q <= mem_q[ridx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NONE;
			base_q  <= '0;
			page_q  <= '0;
			pages_q <= '0;
			mask_q  <= '0;
			ridx_q  <= '0;
			cidx_q  <= '0;
			cmpv_q  <= 1'b0;
			fidx_q  <= '0;
			valid_q <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						op_q    <= q_data.op;
						base_q  <= q_data.page;
						page_q  <= q_data.page;
						pages_q <= (q_data.op == OP_LOOKUP) ? PAGE_W'(1) : q_data.pages;
						mask_q  <= q_data.mask;
						ridx_q  <= '0;
						cmpv_q  <= 1'b0;
						unique case (q_data.op)
							OP_LOOKUP, OP_ADD: state_q <= ST_SCAN;
							OP_CHECK: begin
								if (q_data.pages == '0) begin
									done_q <= 1'b1;
									res_q  <= '{mem_type: 8'd0, range_is_wc: 1'b1,
										status: STAT_OK, slot: 3'd0};
								end else begin
									state_q <= ST_SCAN;
								end
							end
							OP_REJECT: begin
								done_q <= 1'b1;
								res_q  <= '{mem_type: 8'd0, range_is_wc: 1'b0,
									status: q_data.status, slot: 3'd0};
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (page_done) begin
						ridx_q <= '0;
						cmpv_q <= 1'b0;
						priority if (op_q == OP_LOOKUP) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
							res_q   <= '{mem_type: page_type, range_is_wc: 1'b0,
								status: STAT_OK, slot: 3'd0};
						end else if (page_type != TYPE_WC) begin
							if (op_q == OP_CHECK) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
								res_q   <= '0;
							end else begin
								fidx_q  <= '0;
								state_q <= ST_FREE;
							end
						end else if (pages_q == PAGE_W'(1)) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
							if (op_q == OP_CHECK) begin
								res_q <= '{mem_type: 8'd0, range_is_wc: 1'b1,
									status: STAT_OK, slot: 3'd0};
							end else begin
								res_q <= '{mem_type: 8'd0, range_is_wc: 1'b0,
									status: STAT_ALREADY, slot: 3'd0};
							end
						end else begin
							pages_q <= pages_q - 1'b1;
							page_q  <= page_q + 1'b1;
						end
					end else begin
						ridx_q <= ridx_q + 1'b1;
						cmpv_q <= 1'b1;
						cidx_q <= ridx_q[IDX_W-1:0];
					end
				end
				ST_FREE: begin
					priority if (free_end) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						res_q   <= '{mem_type: 8'd0, range_is_wc: 1'b0,
							status: STAT_NO_FREE, slot: 3'd0};
					end else if (wr_en) begin
						valid_q[fidx_q[IDX_W-1:0]] <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						res_q   <= '{mem_type: 8'd0, range_is_wc: 1'b0,
							status: STAT_OK, slot: 3'(fidx_q)};
					end else begin
						fidx_q <= fidx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/memory_type_range_table.sv @@
// top level of the memory type range table
//
//  channel   signals                          handshake
//  request   start, busy, request             taken when start && !busy
//  result    done, result                     shown for one cycle, always taken
//  config    cfg_we, cfg_index, cfg_data      written when cfg_we, no wait
//
// lookup: accepted into the queue, taken by an idle back end, then a scan of up to n entries, n = active entries
// range check: each page walked scans up to n entries; add: a check walk, then a search of up to n slots for a free one
// a two-item queue sits between intake and execution; busy is high while it is full
// reset clears all valid bits at once, no clearing pass
module memory_type_range_table #(
	parameter int unsigned MAX_RANGES = mtrt_pkg::MAX_RANGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  mtrt_pkg::req_t                    request,
	output logic                              busy,
	output logic                              done,
	output mtrt_pkg::res_t                    result,
	input  logic                              cfg_we,
	input  logic [mtrt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mtrt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mtrt_pkg::*;

	logic [7:0] default_type_q;
	logic [3:0] range_count_q;
	logic       wc_supported_q;

	logic push;
	logic pop;
	logic q_empty;
	logic q_full;
	cmd_t f_cmd;
	cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_type_q <= 8'd0;
			range_count_q  <= 4'd8;
			wc_supported_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEFAULT_TYPE: default_type_q <= cfg_data[7:0];
				REG_RANGE_COUNT:  range_count_q  <= cfg_data[3:0];
				REG_WC_SUPPORTED: wc_supported_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mtrt_front u_front (
		.start        (start),
		.request      (request),
		.wc_supported (wc_supported_q),
		.full         (q_full),
		.push         (push),
		.busy         (busy),
		.cmd          (f_cmd)
	);

	mtrt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_cmd),
		.pop    (pop),
		.rdata  (q_cmd),
		.empty  (q_empty),
		.full   (q_full)
	);

	mtrt_back #(
		.MAX_RANGES (MAX_RANGES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (q_cmd),
		.q_empty      (q_empty),
		.pop          (pop),
		.default_type (default_type_q),
		.range_count  (range_count_q),
		.done         (done),
		.result       (result)
	);

endmodule

@@ design/mtrt_checker.sv @@
// port-level checks for the memory type range table, bound to the top level
module mtrt_assertions (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input mtrt_pkg::res_t result
);
	import mtrt_pkg::*;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= STAT_NO_FREE)
		else $error("status code out of range");

	a_slot_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.slot != 3'd0 |->
			result.status == STAT_OK && result.mem_type == 8'd0 && !result.range_is_wc)
		else $error("slot set on a result that is not a write");

	a_status_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != STAT_OK || result.range_is_wc) |-> result.mem_type == 8'd0)
		else $error("mem_type set alongside another answer");

	a_wc_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.range_is_wc |-> result.status == STAT_OK)
		else $error("range answer with add status");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted item");

endmodule

bind memory_type_range_table mtrt_assertions u_mtrt_assertions (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
